### sv/psfp_pkg.sv
// Shared types and constants for the particle sensor frame parser.
// No dependencies; the store, sequencer and top level refer to this package by scoped names.
package psfp_pkg;

	// Stored data bytes, split over an even and an odd byte bank
	localparam int unsigned PAYLOAD_BYTES = 24;
	localparam int unsigned BANK_DEPTH = (PAYLOAD_BYTES + 1) / 2;
	localparam int unsigned BANK_AW = $clog2(BANK_DEPTH);

	// Frame constants
	localparam logic [7:0] HDR_FIRST = 8'h42;
	localparam logic [7:0] HDR_SECOND = 8'h4D;
	localparam logic [7:0] LEN_SHORT = 8'(2 * 9 + 2);
	localparam logic [7:0] LEN_LONG = 8'(2 * 13 + 2);
	localparam logic [3:0] WORDS_SHORT = 4'd6;
	localparam logic [3:0] WORDS_LONG = 4'd12;

	// Result status codes
	localparam logic STATUS_VALID = 1'b0;
	localparam logic STATUS_CSUM_ERR = 1'b1;

	typedef enum logic [1:0] {
		SEQ_RX,
		SEQ_RD,
		SEQ_LD
	} seq_state_t;

	// Payload store access from the sequencer
	typedef struct packed {
		logic               wr_en;
		logic               wr_odd;
		logic [BANK_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
		logic               rd_en;
		logic [BANK_AW-1:0] rd_addr;
	} store_req_t;

	// Result register load control from the sequencer
	typedef struct packed {
		logic       load;
		logic       status;
		logic [3:0] word_index;
		logic       last;
	} res_ctl_t;

endpackage

### sv/psfp_rx_if.sv
// Byte input channel of the particle sensor frame parser.
// Valid/ready handshake; no dependencies.
interface psfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/psfp_res_if.sv
// Result channel of the particle sensor frame parser.
// Valid/ready handshake; no dependencies.
interface psfp_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [3:0]  word_index;
	logic [15:0] value;
	logic        last;

	modport source (output valid, output status, output word_index, output value,
		output last, input ready);
	modport sink (input valid, input status, input word_index, input value,
		input last, output ready);
endinterface

### sv/psfp_store.sv
// Payload byte store: even and odd byte banks, one write port, registered read.
// Depends on psfp_pkg.
module psfp_store (
	input  logic                  clk,
	input  psfp_pkg::store_req_t  req,
	output logic [7:0]            rd_even,
	output logic [7:0]            rd_odd
);

	logic [7:0] mem_even_q [psfp_pkg::BANK_DEPTH];
	logic [7:0] mem_odd_q  [psfp_pkg::BANK_DEPTH];
	logic [7:0] rd_even_q;
	logic [7:0] rd_odd_q;

	// Byte write into the bank picked by the low index bit
	always_ff @(posedge clk) begin
		if (req.wr_en && !req.wr_odd) begin
			mem_even_q[req.wr_addr] <= req.wr_data;
		end
		if (req.wr_en && req.wr_odd) begin
			mem_odd_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Word read: both banks at the same address
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_even_q <= mem_even_q[req.rd_addr];
			rd_odd_q  <= mem_odd_q[req.rd_addr];
		end
	end

	assign rd_even = rd_even_q;
	assign rd_odd  = rd_odd_q;

endmodule

### sv/psfp_seq.sv
// Frame sequencer: header hunt, length check, running sum, checksum compare,
// and the word readout loop over the payload store. Depends on psfp_pkg.
module psfp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	output logic                  in_ready,
	input  logic                  out_free,
	output psfp_pkg::store_req_t  store_req,
	output psfp_pkg::res_ctl_t    res_ctl
);

	psfp_pkg::seq_state_t state_q, state_d;

	logic [4:0]  pos_q;
	logic [4:0]  len_q;
	logic [15:0] sum_q;
	logic [7:0]  ck_hi_q;
	logic [3:0]  word_q;

	logic        rx_xfer;
	logic        at_ck_hi;
	logic        at_ck_lo;
	logic        csum_ok;
	logic [15:0] sum_add;
	logic [4:0]  pidx;
	logic [3:0]  words;
	logic        word_last;

	// Frame position decode
	assign at_ck_hi  = (pos_q >= 5'd4) && ({1'b0, pos_q} == {1'b0, len_q} + 6'd2);
	assign at_ck_lo  = (pos_q >= 5'd4) && ({1'b0, pos_q} == {1'b0, len_q} + 6'd3);
	assign rx_xfer   = in_valid && in_ready;
	assign sum_add   = sum_q + {8'd0, in_byte};
	assign csum_ok   = ({ck_hi_q, in_byte} == sum_q);
	assign pidx      = pos_q - 5'd4;
	assign words     = ({3'd0, len_q} >= psfp_pkg::LEN_LONG) ? psfp_pkg::WORDS_LONG
		: psfp_pkg::WORDS_SHORT;
	assign word_last = (word_q == words - 4'd1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psfp_pkg::SEQ_RX: begin
				if (rx_xfer && at_ck_lo && csum_ok) begin
					state_d = psfp_pkg::SEQ_RD;
				end
			end
			psfp_pkg::SEQ_RD: begin
				state_d = psfp_pkg::SEQ_LD;
			end
			psfp_pkg::SEQ_LD: begin
				if (out_free) begin
					state_d = word_last ? psfp_pkg::SEQ_RX : psfp_pkg::SEQ_RD;
				end
			end
			default: state_d = psfp_pkg::SEQ_RX;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready           = (state_q == psfp_pkg::SEQ_RX) && !(at_ck_lo && !out_free);
		store_req.wr_en    = rx_xfer && (pos_q >= 5'd4) && !at_ck_hi && !at_ck_lo
			&& ({1'b0, pidx} < 6'(psfp_pkg::PAYLOAD_BYTES));
		store_req.wr_odd   = pidx[0];
		store_req.wr_addr  = pidx[psfp_pkg::BANK_AW:1];
		store_req.wr_data  = in_byte;
		store_req.rd_en    = (state_q == psfp_pkg::SEQ_RD);
		store_req.rd_addr  = psfp_pkg::BANK_AW'(word_q);
		res_ctl.load       = 1'b0;
		res_ctl.status     = psfp_pkg::STATUS_VALID;
		res_ctl.word_index = word_q;
		res_ctl.last       = word_last;
		unique case (state_q)
			psfp_pkg::SEQ_RX: begin
				if (rx_xfer && at_ck_lo && !csum_ok) begin
					res_ctl.load       = 1'b1;
					res_ctl.status     = psfp_pkg::STATUS_CSUM_ERR;
					res_ctl.word_index = 4'd0;
					res_ctl.last       = 1'b1;
				end
			end
			psfp_pkg::SEQ_LD: begin
				res_ctl.load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfp_pkg::SEQ_RX;
		end else begin
			state_q <= state_d;
		end
	end

	// Byte parse: position, length and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 5'd0;
			len_q   <= 5'd0;
			sum_q   <= 16'd0;
			ck_hi_q <= 8'd0;
		end else if (rx_xfer) begin
			unique case (pos_q)
				5'd0: begin
					if (in_byte == psfp_pkg::HDR_FIRST) begin
						sum_q <= {8'd0, in_byte};
						pos_q <= 5'd1;
					end
				end
				5'd1: begin
					if (in_byte != psfp_pkg::HDR_SECOND) begin
						pos_q <= 5'd0;
					end else begin
						sum_q <= sum_add;
						pos_q <= 5'd2;
					end
				end
				5'd2: begin
					sum_q <= sum_add;
					len_q <= (in_byte != 8'd0) ? 5'd1 : 5'd0;
					pos_q <= 5'd3;
				end
				5'd3: begin
					if (len_q != 5'd0 || (in_byte != psfp_pkg::LEN_SHORT
						&& in_byte != psfp_pkg::LEN_LONG)) begin
						pos_q <= 5'd0;
					end else begin
						len_q <= in_byte[4:0];
						sum_q <= sum_add;
						pos_q <= 5'd4;
					end
				end
				default: begin
					if (at_ck_hi) begin
						ck_hi_q <= in_byte;
						pos_q   <= pos_q + 5'd1;
					end else if (at_ck_lo) begin
						pos_q <= 5'd0;
					end else begin
						sum_q <= sum_add;
						pos_q <= pos_q + 5'd1;
					end
				end
			endcase
		end
	end

	// Readout word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= 4'd0;
		end else if (rx_xfer && at_ck_lo) begin
			word_q <= 4'd0;
		end else if (state_q == psfp_pkg::SEQ_LD && out_free && !word_last) begin
			word_q <= word_q + 4'd1;
		end
	end

endmodule

### sv/particulate_sensor_frame_parser_core.sv
// Particle sensor frame parser, top level.
// Throughput: one byte transfer per cycle, stalled while a valid frame's words drain and
// at a last checksum byte while a result is still held. An error result shows in the
// cycle after that byte; a valid frame's words each take a store read, then a result load.
// Reset: arst_n clears the parser to header hunt and empties the result register.
module particulate_sensor_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	psfp_rx_if.sink     rx,
	psfp_res_if.source  res
);

	psfp_pkg::store_req_t store_req;
	psfp_pkg::res_ctl_t   res_ctl;
	logic [7:0]           rd_even;
	logic [7:0]           rd_odd;
	logic                 out_free;

	logic        res_valid_q;
	logic        res_status_q;
	logic [3:0]  res_index_q;
	logic [15:0] res_value_q;
	logic        res_last_q;

	assign out_free = !res_valid_q || res.ready;

	psfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_byte   (rx.rx_byte),
		.in_ready  (rx.ready),
		.out_free  (out_free),
		.store_req (store_req),
		.res_ctl   (res_ctl)
	);

	psfp_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; error results carry a zero value
	always_ff @(posedge clk) begin
		if (res_ctl.load) begin
			res_status_q <= res_ctl.status;
			res_index_q  <= res_ctl.word_index;
			res_last_q   <= res_ctl.last;
			res_value_q  <= (res_ctl.status == psfp_pkg::STATUS_CSUM_ERR) ? 16'd0
				: {rd_even, rd_odd};
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.word_index = res_index_q;
	assign res.value      = res_value_q;
	assign res.last       = res_last_q;

endmodule
